[rtl/core/fire_pkg.sv]
// Shared types, constants and the fire palette for the fire effect grid engine.
// Used by fire_ctrl, fire_datapath and fire_effect_grid_engine.
`timescale 1ns / 1ps

package fire_pkg;

   localparam int DEF_GRID_COLS  = 32;
   localparam int DEF_GRID_ROWS  = 32;
   localparam int DEF_ZOOM_SHIFT = 2;

   localparam int HEAT_W  = 6;
   localparam int COORD_W = 7;
   localparam int RGB_W   = 18;

   localparam logic [HEAT_W-1:0] HEAT_MAX    = 6'd63;
   localparam logic [HEAT_W-1:0] HEAT_ZERO   = 6'd0;
   localparam logic [31:0]       NOISE_RESET = 32'd31421;
   localparam logic [31:0]       NOISE_MIX   = 32'd6927;

   typedef enum logic [1:0] {
      FUNC_UPDATE = 2'd0,
      FUNC_PIXEL  = 2'd1,
      FUNC_SOURCE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_wr;    // write one cell of the clearing pass
      logic start;     // capture level, rewind column and row counters
      logic pix_sel;   // read port takes the pixel address from the request
      logic rd_hold;   // hold the read data register
      logic fill_wr;   // write one cell of row 0 with the captured level
      logic upd_wr;    // write one moved cell, advance noise and counters
      logic pix_load;  // load the colour of the cell just read into the output
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic col_last;
      logic row_last;
      logic out_free;
   } stat_type;

   // Palette entry: red [17:12], green [11:6], blue [5:0]
   function automatic logic [RGB_W-1:0] pal_entry(input logic [5:0] r, input logic [5:0] g,
                                                  input logic [5:0] b);
      return {r, g, b};
   endfunction

   function automatic logic [RGB_W-1:0] pal_lookup(input logic [4:0] idx);
      logic [RGB_W-1:0] e;
      case (idx)
         5'd0:  e = pal_entry(6'h01, 6'h01, 6'h01);
         5'd1:  e = pal_entry(6'h07, 6'h01, 6'h01);
         5'd2:  e = pal_entry(6'h0b, 6'h03, 6'h01);
         5'd3:  e = pal_entry(6'h11, 6'h03, 6'h01);
         5'd4:  e = pal_entry(6'h15, 6'h05, 6'h01);
         5'd5:  e = pal_entry(6'h19, 6'h07, 6'h01);
         5'd6:  e = pal_entry(6'h1d, 6'h07, 6'h01);
         5'd7:  e = pal_entry(6'h27, 6'h0b, 6'h01);
         5'd8:  e = pal_entry(6'h2b, 6'h0f, 6'h01);
         5'd9:  e = pal_entry(6'h2f, 6'h11, 6'h01);
         5'd10: e = pal_entry(6'h31, 6'h11, 6'h01);
         5'd11: e = pal_entry(6'h37, 6'h15, 6'h01);
         5'd12: e = pal_entry(6'h37, 6'h15, 6'h01);
         5'd13: e = pal_entry(6'h35, 6'h17, 6'h01);
         5'd14: e = pal_entry(6'h35, 6'h17, 6'h01);
         5'd15: e = pal_entry(6'h35, 6'h19, 6'h03);
         5'd16: e = pal_entry(6'h33, 6'h1d, 6'h03);
         5'd17: e = pal_entry(6'h33, 6'h1f, 6'h03);
         5'd18: e = pal_entry(6'h33, 6'h21, 6'h05);
         5'd19: e = pal_entry(6'h31, 6'h21, 6'h05);
         5'd20: e = pal_entry(6'h31, 6'h25, 6'h07);
         5'd21: e = pal_entry(6'h2f, 6'h27, 6'h07);
         5'd22: e = pal_entry(6'h2f, 6'h27, 6'h07);
         5'd23: e = pal_entry(6'h2f, 6'h29, 6'h09);
         5'd24: e = pal_entry(6'h2f, 6'h29, 6'h09);
         5'd25: e = pal_entry(6'h2f, 6'h2b, 6'h0b);
         5'd26: e = pal_entry(6'h2d, 6'h2b, 6'h0b);
         5'd27: e = pal_entry(6'h2d, 6'h2d, 6'h0b);
         5'd28: e = pal_entry(6'h33, 6'h33, 6'h1b);
         5'd29: e = pal_entry(6'h37, 6'h37, 6'h27);
         5'd30: e = pal_entry(6'h3b, 6'h3b, 6'h31);
         default: e = pal_entry(6'h3f, 6'h3f, 6'h3f);
      endcase
      return e;
   endfunction

endpackage

[rtl/core/fire_ctrl.sv]
// Sequencer for the fire effect grid engine: clearing pass, item decode and passes.
// Depends on fire_pkg for command, status and function code types.
`timescale 1ns / 1ps

module fire_ctrl
   import fire_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  func_type func,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_FILL   = 6'b000100,
      ST_UPD_RD = 6'b001000,
      ST_UPD_WR = 6'b010000,
      ST_PIX    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.pix_sel = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               unique case (func)
                  FUNC_UPDATE: state_in = ST_UPD_RD;
                  FUNC_PIXEL:  state_in = ST_PIX;
                  FUNC_SOURCE: state_in = ST_FILL;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (stat.col_last) state_in = ST_IDLE;
         end
         ST_UPD_RD: begin
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cmd.upd_wr = 1'b1;
            if (stat.col_last && stat.row_last) state_in = ST_IDLE;
            else state_in = ST_UPD_RD;
         end
         ST_PIX: begin
            // hold the cell just read until the output register can take the colour
            cmd.rd_hold = 1'b1;
            if (stat.out_free) begin
               cmd.pix_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

[rtl/core/fire_datapath.sv]
// Datapath of the fire effect grid engine: heat grid memory, noise, counters, output register.
// Depends on fire_pkg for commands, status, constants and the palette.
`timescale 1ns / 1ps

module fire_datapath
   import fire_pkg::*;
#(
   parameter int GRID_COLS  = DEF_GRID_COLS,
   parameter int GRID_ROWS  = DEF_GRID_ROWS,
   parameter int ZOOM_SHIFT = DEF_ZOOM_SHIFT
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [COORD_W-1:0] pixel_x,
   input  logic [COORD_W-1:0] pixel_y,
   input  logic [HEAT_W-1:0]  source_level,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RGB_W-1:0]   rsp_rgb
);

   localparam int CELLS  = GRID_ROWS * GRID_COLS;
   localparam int COL_W  = $clog2(GRID_COLS);
   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int DST_W  = COL_W + 1;

   logic [HEAT_W-1:0] mem [CELLS];
   logic [HEAT_W-1:0] rdata_ff;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [HEAT_W-1:0] level_ff, level_in;
   logic [31:0]       noise_ff, noise_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RGB_W-1:0]  rgb_ff, rgb_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr, pix_addr, upd_rd_addr;
   logic [HEAT_W-1:0] wr_data, heat_new;
   logic [COORD_W-1:0] pcol, prow;
   logic [31:0]       noise_asr;
   logic [DST_W-1:0]  dst_sum, dst;
   logic [RGB_W-1:0]  entry;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(GRID_COLS) + ADDR_W'(c);
   endfunction

   // pixel coordinate scaled down and clamped to the grid
   always_comb begin
      pcol = pixel_x >> ZOOM_SHIFT;
      prow = pixel_y >> ZOOM_SHIFT;
      if (pcol > COORD_W'(GRID_COLS - 1)) pcol = COORD_W'(GRID_COLS - 1);
      if (prow > COORD_W'(GRID_ROWS - 1)) prow = COORD_W'(GRID_ROWS - 1);
      pix_addr = cell_addr(ROW_W'(prow), COL_W'(pcol));
   end

   assign upd_rd_addr = cell_addr(row_ff - ROW_W'(1), col_ff);
   assign rd_addr     = cmd.pix_sel ? pix_addr : upd_rd_addr;

   // decay of the cell below, using noise before it advances
   always_comb begin
      if (rdata_ff > HEAT_W'(3)) heat_new = rdata_ff - HEAT_W'(1) - HEAT_W'(noise_ff[1:0]);
      else if (rdata_ff > HEAT_W'(1)) heat_new = rdata_ff - HEAT_W'(noise_ff[0]);
      else heat_new = HEAT_ZERO;
   end

   assign noise_asr = 32'($signed(noise_ff) >>> 5);

   always_comb begin
      noise_in = noise_ff;
      if (cmd.upd_wr) noise_in = ((noise_ff << 5) ^ NOISE_MIX) + (noise_asr ^ 32'(col_ff));
   end

   // jittered destination column, wrapped once
   always_comb begin
      dst_sum = DST_W'(col_ff) + DST_W'(noise_in[1:0]);
      if (dst_sum >= DST_W'(GRID_COLS)) dst = dst_sum - DST_W'(GRID_COLS);
      else dst = dst_sum;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = upd_rd_addr;
      wr_data = heat_new;
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = (clr_ff < ADDR_W'(GRID_COLS)) ? HEAT_MAX : HEAT_ZERO;
      end else if (cmd.fill_wr) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(col_ff);
         wr_data = level_ff;
      end else if (cmd.upd_wr) begin
         wr_en   = 1'b1;
         wr_addr = cell_addr(row_ff, COL_W'(dst));
         wr_data = heat_new;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (!cmd.rd_hold) rdata_ff <= mem[rd_addr];
   end

   assign stat.clr_last = (clr_ff == ADDR_W'(CELLS - 1));
   assign stat.col_last = (col_ff == COL_W'(GRID_COLS - 1));
   assign stat.row_last = (row_ff == ROW_W'(GRID_ROWS - 1));
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      clr_in   = cmd.clr_wr ? clr_ff + ADDR_W'(1) : clr_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      level_in = level_ff;
      if (cmd.start) begin
         col_in   = '0;
         row_in   = ROW_W'(1);
         level_in = source_level;
      end else if (cmd.fill_wr || cmd.upd_wr) begin
         if (stat.col_last) begin
            col_in = '0;
            if (cmd.upd_wr) row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign entry = pal_lookup(rdata_ff[5:1]);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rgb_in       = rgb_ff;
      if (cmd.pix_load) begin
         rsp_valid_in = 1'b1;
         rgb_in       = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= ROW_W'(1);
         noise_ff     <= NOISE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         noise_ff     <= noise_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      rgb_ff   <= rgb_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_rgb    = rgb_ff;

endmodule

[rtl/core/fire_effect_grid_engine.sv]
// Top level of the fire effect grid engine: stream ports, controller and datapath.
// Depends on fire_pkg, fire_ctrl and fire_datapath.
`timescale 1ns / 1ps
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tuser: func; tdata: pixel_x, pixel_y, source_level
//  rsp      out        rsp_tvalid/rsp_tready  tdata: red, green, blue (pixel items only)
//
//  Steps from acceptance until req_tready is high again: a pixel item is accepted with the
//  grid memory read, then goes through palette and output register; an update item does a
//  registered read then a write per cell of rows 1 to GRID_ROWS-1; a source item writes each
//  cell of row 0 with source_level; an unused code does nothing and returns to idle.
//  Reset: a clearing pass over all GRID_ROWS*GRID_COLS cells writes row 0 to 63 and the rest
//  to 0; req_tready stays low until it ends.
//  Stalls: a pixel result waits in the output register; the next item is taken meanwhile,
//  and a further pixel item holds in its last cycle until the register frees.

module fire_effect_grid_engine
   import fire_pkg::*;
#(
   parameter int GRID_COLS  = DEF_GRID_COLS,
   parameter int GRID_ROWS  = DEF_GRID_ROWS,
   parameter int ZOOM_SHIFT = DEF_ZOOM_SHIFT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [6:0] pixel_x, [13:7] pixel_y, [19:14] source_level
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [5:0] red, [11:6] green, [17:12] blue
);

   cmd_type          cmd;
   stat_type         stat;
   logic [RGB_W-1:0] rgb;

   fire_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .func       (func_type'(req_tuser)),
      .stat       (stat),
      .cmd        (cmd)
   );

   fire_datapath #(
      .GRID_COLS  (GRID_COLS),
      .GRID_ROWS  (GRID_ROWS),
      .ZOOM_SHIFT (ZOOM_SHIFT)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .pixel_x      (req_tdata[6:0]),
      .pixel_y      (req_tdata[13:7]),
      .source_level (req_tdata[19:14]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_rgb      (rgb)
   );

   // palette entry holds red high; put red in the lowest bits of the transaction
   assign rsp_tdata = {6'd0, rgb[5:0], rgb[11:6], rgb[17:12]};

endmodule
